[src/uft_pkg.sv]
// ----------------------------------------------------------------------------
// uft_pkg
// Shared types and constants for the union-find table: operation codes,
// controller states, memory command bundle and presence epoch tags.
// ----------------------------------------------------------------------------
package uft_pkg;

    // width of an element slot field on the ports
    localparam int ELEM_W = 8;

    // presence epoch tag stored next to each parent link
    localparam int TAG_W = 8;
    localparam logic [TAG_W-1:0] EPOCH_NONE  = '0;
    localparam logic [TAG_W-1:0] EPOCH_FIRST = TAG_W'(1);
    localparam logic [TAG_W-1:0] EPOCH_MAX   = '1;

    // operation codes of an input transfer
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_FIND   = 2'd1,
        OP_MERGE  = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_CHK_A,
        ST_CHK_B,
        ST_WALK,
        ST_FINISH
    } state_t;

    // memory port enables
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_cmd_t;

endpackage

[src/uft_store.sv]
// ----------------------------------------------------------------------------
// uft_store
// Slot memory: one entry per slot holding {epoch tag, parent link}.
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module uft_store #(
    parameter int DEPTH = 256
) (
    input  logic                                        aclk,
    input  uft_pkg::mem_cmd_t                           mem_cmd,
    input  logic [$clog2(DEPTH)-1:0]                    rd_addr,
    input  logic [$clog2(DEPTH)-1:0]                    wr_addr,
    input  logic [uft_pkg::TAG_W+$clog2(DEPTH)-1:0]     wr_data,
    output logic [uft_pkg::TAG_W+$clog2(DEPTH)-1:0]     rd_data
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int WORD_W = uft_pkg::TAG_W + ADDR_W;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (mem_cmd.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered read data
    always_ff @(posedge aclk) begin
        if (mem_cmd.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/uft_ctrl.sv]
// ----------------------------------------------------------------------------
// uft_ctrl
// Operation sequencer: decodes a transfer, reads the slot memory, walks parent
// links one per cycle, writes back inserts, merge links and tag scrubs, and
// holds the result in an output register.
// ----------------------------------------------------------------------------
module uft_ctrl #(
    parameter int SLOTS = 256
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    // input channel
    input  logic                                        s_valid,
    output logic                                        s_ready,
    input  logic [1:0]                                  s_operation,
    input  logic [uft_pkg::ELEM_W-1:0]                  s_element_a,
    input  logic [uft_pkg::ELEM_W-1:0]                  s_element_b,
    // result channel
    output logic                                        m_valid,
    input  logic                                        m_ready,
    output logic                                        m_success,
    output logic                                        m_found,
    output logic [uft_pkg::ELEM_W-1:0]                  m_root_slot,
    // slot memory
    output uft_pkg::mem_cmd_t                           mem_cmd,
    output logic [$clog2(SLOTS)-1:0]                    mem_rd_addr,
    output logic [$clog2(SLOTS)-1:0]                    mem_wr_addr,
    output logic [uft_pkg::TAG_W+$clog2(SLOTS)-1:0]     mem_wr_data,
    input  logic [uft_pkg::TAG_W+$clog2(SLOTS)-1:0]     mem_rd_data
);

    localparam int IDX_W  = $clog2(SLOTS);
    localparam int CMP_W  = 17;
    localparam int WORD_W = uft_pkg::TAG_W + IDX_W;
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SLOTS - 1);

    uft_pkg::state_t state_reg, state_next;
    uft_pkg::op_t    op_reg, op_next, op_in;

    logic [IDX_W-1:0]          a_reg, a_next;
    logic [IDX_W-1:0]          b_reg, b_next;
    logic                      a_ok_reg, a_ok_next;
    logic                      b_ok_reg, b_ok_next;
    logic [IDX_W-1:0]          cur_reg, cur_next;
    logic [IDX_W-1:0]          x_reg, x_next;
    logic                      phase_reg, phase_next;
    logic [uft_pkg::TAG_W-1:0] epoch_reg, epoch_next;
    logic [IDX_W-1:0]          sweep_reg, sweep_next;
    logic                      sweep_resp_reg, sweep_resp_next;
    logic                      res_success_reg, res_success_next;
    logic                      res_found_reg, res_found_next;
    logic [IDX_W-1:0]          res_root_reg, res_root_next;
    logic                      m_valid_reg, m_valid_next;
    logic                      m_success_reg, m_success_next;
    logic                      m_found_reg, m_found_next;
    logic [IDX_W-1:0]          m_root_reg, m_root_next;

    logic [CMP_W-1:0]          a_wide, b_wide, root_wide;
    logic [IDX_W-1:0]          a_idx, b_idx;
    logic                      a_ok, b_ok;
    logic [uft_pkg::TAG_W-1:0] rd_tag;
    logic [IDX_W-1:0]          rd_link;
    logic                      hit, present_a, is_root, out_free, last_sweep;

    // decode input slots and range checks
    assign op_in   = uft_pkg::op_t'(s_operation);
    assign a_wide  = CMP_W'(s_element_a);
    assign b_wide  = CMP_W'(s_element_b);
    assign a_idx   = a_wide[IDX_W-1:0];
    assign b_idx   = b_wide[IDX_W-1:0];
    assign a_ok    = a_wide < CMP_W'(SLOTS);
    assign b_ok    = b_wide < CMP_W'(SLOTS);

    // split the read word
    assign rd_tag     = mem_rd_data[WORD_W-1 -: uft_pkg::TAG_W];
    assign rd_link    = mem_rd_data[IDX_W-1:0];
    assign hit        = rd_tag == epoch_reg;
    assign present_a  = a_ok_reg && hit;
    assign is_root    = rd_link == cur_reg;
    assign out_free   = !m_valid_reg || m_ready;
    assign last_sweep = sweep_reg == LAST_SLOT;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            uft_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (op_in == uft_pkg::OP_CLEAR) begin
                        state_next = (epoch_reg == uft_pkg::EPOCH_MAX) ?
                                     uft_pkg::ST_SWEEP : uft_pkg::ST_FINISH;
                    end else begin
                        state_next = uft_pkg::ST_CHK_A;
                    end
                end
            end
            uft_pkg::ST_SWEEP: begin
                if (last_sweep) begin
                    state_next = sweep_resp_reg ? uft_pkg::ST_FINISH : uft_pkg::ST_IDLE;
                end
            end
            uft_pkg::ST_CHK_A: begin
                case (op_reg)
                    uft_pkg::OP_FIND: begin
                        state_next = present_a ? uft_pkg::ST_WALK : uft_pkg::ST_FINISH;
                    end
                    uft_pkg::OP_MERGE: begin
                        state_next = (present_a && b_ok_reg) ?
                                     uft_pkg::ST_CHK_B : uft_pkg::ST_FINISH;
                    end
                    default: begin
                        state_next = uft_pkg::ST_FINISH;
                    end
                endcase
            end
            uft_pkg::ST_CHK_B: begin
                state_next = hit ? uft_pkg::ST_WALK : uft_pkg::ST_FINISH;
            end
            uft_pkg::ST_WALK: begin
                if (is_root && !(op_reg == uft_pkg::OP_MERGE && !phase_reg)) begin
                    state_next = uft_pkg::ST_FINISH;
                end
            end
            uft_pkg::ST_FINISH: begin
                if (out_free) begin
                    state_next = uft_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = uft_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath registers
    always_comb begin
        op_next          = op_reg;
        a_next           = a_reg;
        b_next           = b_reg;
        a_ok_next        = a_ok_reg;
        b_ok_next        = b_ok_reg;
        cur_next         = cur_reg;
        x_next           = x_reg;
        phase_next       = phase_reg;
        epoch_next       = epoch_reg;
        sweep_next       = sweep_reg;
        sweep_resp_next  = sweep_resp_reg;
        res_success_next = res_success_reg;
        res_found_next   = res_found_reg;
        res_root_next    = res_root_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_success_next   = m_success_reg;
        m_found_next     = m_found_reg;
        m_root_next      = m_root_reg;
        case (state_reg)
            uft_pkg::ST_IDLE: begin
                if (s_valid) begin
                    op_next          = op_in;
                    a_next           = a_idx;
                    b_next           = b_idx;
                    a_ok_next        = a_ok;
                    b_ok_next        = b_ok;
                    res_success_next = 1'b0;
                    res_found_next   = 1'b0;
                    res_root_next    = '0;
                    if (op_in == uft_pkg::OP_CLEAR) begin
                        // advance the epoch; on wrap, scrub every tag first
                        if (epoch_reg == uft_pkg::EPOCH_MAX) begin
                            epoch_next      = uft_pkg::EPOCH_FIRST;
                            sweep_next      = '0;
                            sweep_resp_next = 1'b1;
                        end else begin
                            epoch_next = epoch_reg + uft_pkg::TAG_W'(1);
                        end
                    end
                end
            end
            uft_pkg::ST_SWEEP: begin
                if (!last_sweep) begin
                    sweep_next = sweep_reg + IDX_W'(1);
                end
            end
            uft_pkg::ST_CHK_A: begin
                case (op_reg)
                    uft_pkg::OP_INSERT: begin
                        res_success_next = a_ok_reg && !hit;
                    end
                    uft_pkg::OP_FIND: begin
                        cur_next = a_reg;
                    end
                    default: begin
                    end
                endcase
            end
            uft_pkg::ST_CHK_B: begin
                cur_next   = a_reg;
                phase_next = 1'b0;
            end
            uft_pkg::ST_WALK: begin
                if (is_root) begin
                    if (op_reg == uft_pkg::OP_MERGE) begin
                        if (!phase_reg) begin
                            // root of a found: start the walk from b
                            x_next     = cur_reg;
                            cur_next   = b_reg;
                            phase_next = 1'b1;
                        end else begin
                            res_success_next = 1'b1;
                        end
                    end else begin
                        res_found_next = 1'b1;
                        res_root_next  = cur_reg;
                    end
                end else begin
                    cur_next = rd_link;
                end
            end
            uft_pkg::ST_FINISH: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_success_next = res_success_reg;
                    m_found_next   = res_found_reg;
                    m_root_next    = res_root_reg;
                end
            end
            default: begin
            end
        endcase
    end

    // memory requests and input ready
    always_comb begin
        s_ready     = state_reg == uft_pkg::ST_IDLE;
        mem_cmd     = '0;
        mem_rd_addr = cur_reg;
        mem_wr_addr = a_reg;
        mem_wr_data = {epoch_reg, a_reg};
        case (state_reg)
            uft_pkg::ST_IDLE: begin
                mem_cmd.rd_en = s_valid;
                mem_rd_addr   = a_idx;
            end
            uft_pkg::ST_SWEEP: begin
                mem_cmd.wr_en = 1'b1;
                mem_wr_addr   = sweep_reg;
                mem_wr_data   = {uft_pkg::EPOCH_NONE, IDX_W'(0)};
            end
            uft_pkg::ST_CHK_A: begin
                case (op_reg)
                    uft_pkg::OP_INSERT: begin
                        mem_cmd.wr_en = a_ok_reg && !hit;
                    end
                    uft_pkg::OP_FIND: begin
                        mem_cmd.rd_en = present_a;
                        mem_rd_addr   = a_reg;
                    end
                    uft_pkg::OP_MERGE: begin
                        mem_cmd.rd_en = present_a && b_ok_reg;
                        mem_rd_addr   = b_reg;
                    end
                    default: begin
                    end
                endcase
            end
            uft_pkg::ST_CHK_B: begin
                mem_cmd.rd_en = hit;
                mem_rd_addr   = a_reg;
            end
            uft_pkg::ST_WALK: begin
                if (is_root) begin
                    if (op_reg == uft_pkg::OP_MERGE) begin
                        if (!phase_reg) begin
                            mem_cmd.rd_en = 1'b1;
                            mem_rd_addr   = b_reg;
                        end else begin
                            // link root(a) under root(b)
                            mem_cmd.wr_en = 1'b1;
                            mem_wr_addr   = x_reg;
                            mem_wr_data   = {epoch_reg, cur_reg};
                        end
                    end
                end else begin
                    mem_cmd.rd_en = 1'b1;
                    mem_rd_addr   = rd_link;
                end
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= uft_pkg::ST_SWEEP;
            epoch_reg      <= uft_pkg::EPOCH_FIRST;
            sweep_reg      <= '0;
            sweep_resp_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            epoch_reg      <= epoch_next;
            sweep_reg      <= sweep_next;
            sweep_resp_reg <= (state_reg == uft_pkg::ST_FINISH) ? 1'b0 : sweep_resp_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        op_reg          <= op_next;
        a_reg           <= a_next;
        b_reg           <= b_next;
        a_ok_reg        <= a_ok_next;
        b_ok_reg        <= b_ok_next;
        cur_reg         <= cur_next;
        x_reg           <= x_next;
        phase_reg       <= phase_next;
        res_success_reg <= res_success_next;
        res_found_reg   <= res_found_next;
        res_root_reg    <= res_root_next;
        m_success_reg   <= m_success_next;
        m_found_reg     <= m_found_next;
        m_root_reg      <= m_root_next;
    end

    // drive the result channel
    assign root_wide   = CMP_W'(m_root_reg);
    assign m_valid     = m_valid_reg;
    assign m_success   = m_success_reg;
    assign m_found     = m_found_reg;
    assign m_root_slot = root_wide[uft_pkg::ELEM_W-1:0];

    // never read and write the same entry in one cycle
    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_cmd.rd_en && mem_cmd.wr_en && mem_rd_addr == mem_wr_addr))
        else $error("slot memory read and write collide");

    // one item at a time: no transfer right after a transfer
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while an item is in flight");

    // a result only appears out of the finish step
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == uft_pkg::ST_FINISH))
        else $error("result raised outside finish");

    // the live epoch never matches a scrubbed tag
    a_epoch_live: assert property (@(posedge aclk) disable iff (!aresetn)
        epoch_reg != uft_pkg::EPOCH_NONE)
        else $error("epoch collides with empty tag");

endmodule

[src/union_find_table_unit.sv]
// Flow: insert, find and merge read slot a in IDLE and check it in CHK_A; find
// then walks a's chain, merge checks b in CHK_B and walks both chains; clear
// goes to FINISH (through SWEEP on a wrap); result stalls hold FINISH.
// Throughput: one item at a time; the walk does one parent link per cycle
// through the slot memory's single read port, and input reopens after the result.
// Reset: a scrub pass writes an empty tag to every slot; input is held off
// until it ends. A clear that wraps the 8-bit epoch runs the same pass.
// ----------------------------------------------------------------------------
// union_find_table_unit
// Disjoint-set table over SLOTS element slots: insert, find, merge and clear
// on a tagged slot memory, root walk without path compression.
// ----------------------------------------------------------------------------
module union_find_table_unit #(
    parameter int SLOTS = 256
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [1:0]                     s_operation,
    input  logic [uft_pkg::ELEM_W-1:0]     s_element_a,
    input  logic [uft_pkg::ELEM_W-1:0]     s_element_b,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_success,
    output logic                           m_found,
    output logic [uft_pkg::ELEM_W-1:0]     m_root_slot
);

    localparam int IDX_W  = $clog2(SLOTS);
    localparam int WORD_W = uft_pkg::TAG_W + IDX_W;

    uft_pkg::mem_cmd_t  mem_cmd;
    logic [IDX_W-1:0]   mem_rd_addr;
    logic [IDX_W-1:0]   mem_wr_addr;
    logic [WORD_W-1:0]  mem_wr_data;
    logic [WORD_W-1:0]  mem_rd_data;

    // sequencer
    uft_ctrl #(
        .SLOTS(SLOTS)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_element_a (s_element_a),
        .s_element_b (s_element_b),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_success   (m_success),
        .m_found     (m_found),
        .m_root_slot (m_root_slot),
        .mem_cmd     (mem_cmd),
        .mem_rd_addr (mem_rd_addr),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_data (mem_rd_data)
    );

    // slot memory
    uft_store #(
        .DEPTH(SLOTS)
    ) u_store (
        .aclk    (aclk),
        .mem_cmd (mem_cmd),
        .rd_addr (mem_rd_addr),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_data (mem_rd_data)
    );

endmodule
